// ----- rtl/core/nht_pkg.sv -----
// Shared types, constants and header layout functions for the NAT64 header translator.
`timescale 1ns / 1ps

package nht_pkg;

	localparam int ETH_LEN           = 14;
	localparam int V4_END            = 34;
	localparam int V6_END            = 54;
	localparam int STORE_DEPTH       = 54;
	localparam int HDR_GROWTH        = 20;
	localparam int OQ_DEPTH          = 4;

	localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
	localparam logic [15:0] ETHERTYPE_V6 = 16'h86dd;
	localparam logic [7:0]  PFX_B1       = 8'h64;
	localparam logic [7:0]  PFX_B2       = 8'hff;
	localparam logic [7:0]  PFX_B3       = 8'h9b;
	localparam logic [7:0]  V4_VER_IHL   = 8'h45;
	localparam logic [7:0]  V6_VER       = 8'h60;
	localparam logic [15:0] DF_FLAG      = 16'h01 << 14;
	localparam logic [15:0] CSUM_MASK    = 16'hffff;
	// constant words of the IPv4 header: version/IHL/TOS and flags
	localparam logic [19:0] CSUM_INIT    = {4'd0, V4_VER_IHL, 8'h00} + {4'd0, DF_FLAG};

	typedef enum logic [1:0] {
		KIND_UNKNOWN,
		KIND_V4,
		KIND_V6,
		KIND_OTHER
	} kind_t;

	typedef enum logic [2:0] {
		OP_PASS,
		OP_DROP,
		OP_HDR_OTHER,
		OP_HDR_TO_V6,
		OP_HDR_TO_V4
	} op_t;

	typedef enum logic [1:0] {
		VERDICT_XLAT = 2'd0,
		VERDICT_PASS = 2'd1,
		VERDICT_DROP = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		SEL_CONST,
		SEL_RAM,
		SEL_LEN_HI,
		SEL_LEN_LO,
		SEL_CS_HI,
		SEL_CS_LO
	} sel_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_frame;
		logic [1:0] verdict;
	} result_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       last;
		verdict_t   verdict;
	} cmd_t;

	typedef struct packed {
		logic [15:0] len;
		logic [15:0] csum;
	} hdr_info_t;

	typedef struct packed {
		sel_t       sel;
		logic [5:0] addr;
		logic [7:0] value;
	} src_t;

	function automatic logic [5:0] hdr_last(op_t op);
		logic [5:0] r;
		case (op)
			OP_HDR_TO_V6: r = 6'(V6_END - 1);
			OP_HDR_TO_V4: r = 6'(V4_END - 1);
			default:      r = 6'(ETH_LEN - 1);
		endcase
		return r;
	endfunction

	// Source of output byte k of an emitted header.
	function automatic src_t hdr_src(op_t op, logic [5:0] k);
		src_t s;
		logic [5:0] i;
		logic [5:0] j;
		logic [5:0] base;
		s.sel   = SEL_CONST;
		s.addr  = '0;
		s.value = '0;
		i       = k - 6'(ETH_LEN);
		j       = (k < 6'd38) ? k - 6'd22 : k - 6'd38;
		base    = (k < 6'd38) ? 6'd26 : 6'd30;
		// unknown ethertype: header goes out as received
		if (op == OP_HDR_OTHER) begin
			s.sel  = SEL_RAM;
			s.addr = k;
		end else if (k < 6'd6) begin
			s.sel  = SEL_RAM;
			s.addr = k + 6'd6;
		end else if (k < 6'd12) begin
			s.sel  = SEL_RAM;
			s.addr = k - 6'd6;
		end else if (op == OP_HDR_TO_V6) begin
			if (k == 6'd12) s.value = ETHERTYPE_V6[15:8];
			else if (k == 6'd13) s.value = ETHERTYPE_V6[7:0];
			else if (k == 6'd14) s.value = V6_VER;
			else if (k == 6'd18) s.sel = SEL_LEN_HI;
			else if (k == 6'd19) s.sel = SEL_LEN_LO;
			else if (k == 6'd20) begin
				s.sel  = SEL_RAM;
				s.addr = 6'd23;
			end else if (k == 6'd21) begin
				s.sel  = SEL_RAM;
				s.addr = 6'd22;
			end else if (k >= 6'd22) begin
				if (j == 6'd1) s.value = PFX_B1;
				else if (j == 6'd2) s.value = PFX_B2;
				else if (j == 6'd3) s.value = PFX_B3;
				else if (j >= 6'd12) begin
					s.sel  = SEL_RAM;
					s.addr = base + j - 6'd12;
				end
			end
		end else begin
			if (k == 6'd12) s.value = ETHERTYPE_V4[15:8];
			else if (k == 6'd13) s.value = ETHERTYPE_V4[7:0];
			else if (i == 6'd0) s.value = V4_VER_IHL;
			else if (i == 6'd2) s.sel = SEL_LEN_HI;
			else if (i == 6'd3) s.sel = SEL_LEN_LO;
			else if (i == 6'd6) s.value = DF_FLAG[15:8];
			else if (i == 6'd8) begin
				s.sel  = SEL_RAM;
				s.addr = 6'd21;
			end else if (i == 6'd9) begin
				s.sel  = SEL_RAM;
				s.addr = 6'd20;
			end else if (i == 6'd10) s.sel = SEL_CS_HI;
			else if (i == 6'd11) s.sel = SEL_CS_LO;
			else if (i >= 6'd12 && i < 6'd16) begin
				s.sel  = SEL_RAM;
				s.addr = i + 6'd22;
			end else if (i >= 6'd16) begin
				s.sel  = SEL_RAM;
				s.addr = i + 6'd34;
			end
		end
		return s;
	endfunction

endpackage

// ----- rtl/core/nht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 54
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/nht_front.sv -----
// Front end: buffers header bytes, classifies the frame and issues commands.
`timescale 1ns / 1ps

module nht_front import nht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  logic       accept,
	input  logic       hdr_done,
	output cmd_t       cmd,
	output logic       cmd_push,
	output logic       wr_en,
	output logic [5:0] wr_addr,
	output logic [7:0] wr_data,
	output hdr_info_t  info,
	output logic       hdr_busy
);

	logic [5:0]  pos_q, pos_d, pos_inc;
	kind_t       kind_q, kind_d;
	logic [7:0]  et_hi_q, et_hi_d;
	logic [19:0] sum_q, sum_d;
	logic [15:0] len_q, len_d, csum_q, csum_d, tl;
	logic        busy_q, set_busy;
	logic [7:0]  b;
	logic        last;
	logic [5:0]  need;
	logic [19:0] s0;
	logic [16:0] f1;
	logic [15:0] f2;

	assign b        = item.frame_byte;
	assign last     = item.last_byte;
	assign pos_inc  = pos_q + 6'd1;
	assign need     = (kind_q == KIND_V4) ? 6'(V4_END) : 6'(V6_END);
	assign tl       = len_q + 16'(HDR_GROWTH);
	assign wr_addr  = pos_q;
	assign wr_data  = b;
	assign info     = '{len: len_q, csum: csum_q};
	assign hdr_busy = busy_q;

	// ones'-complement fold of the running sum plus total length
	assign s0 = sum_d + {4'd0, tl};
	assign f1 = {1'b0, s0[15:0]} + {13'd0, s0[19:16]};
	assign f2 = f1[15:0] + {15'd0, f1[16]};

	always_comb begin
		cmd      = '{op: OP_PASS, data: b, last: last, verdict: VERDICT_XLAT};
		cmd_push = 1'b0;
		wr_en    = 1'b0;
		set_busy = 1'b0;
		pos_d    = pos_q;
		kind_d   = kind_q;
		et_hi_d  = et_hi_q;
		sum_d    = sum_q;
		len_d    = len_q;
		csum_d   = csum_q;
		if (accept) begin
			unique case (kind_q)
				KIND_UNKNOWN: begin
					wr_en = 1'b1;
					pos_d = pos_inc;
					if (pos_q == 6'd12) et_hi_d = b;
					if (pos_inc == 6'(ETH_LEN)) begin
						sum_d = CSUM_INIT;
						if ({et_hi_q, b} == ETHERTYPE_V4) kind_d = KIND_V4;
						else if ({et_hi_q, b} == ETHERTYPE_V6) kind_d = KIND_V6;
						else begin
							kind_d      = KIND_OTHER;
							cmd_push    = 1'b1;
							cmd.op      = OP_HDR_OTHER;
							cmd.verdict = VERDICT_PASS;
							set_busy    = 1'b1;
						end
					end
				end
				KIND_OTHER: begin
					cmd_push    = 1'b1;
					cmd.verdict = VERDICT_PASS;
				end
				KIND_V4, KIND_V6: begin
					if (pos_q < need) begin
						wr_en = 1'b1;
						pos_d = pos_inc;
						if (kind_q == KIND_V4) begin
							if (pos_q == 6'd16) len_d[15:8] = b;
							if (pos_q == 6'd17) len_d[7:0]  = b;
						end else begin
							if (pos_q == 6'd18) len_d[15:8] = b;
							if (pos_q == 6'd19) len_d[7:0]  = b;
							// protocol, hop limit and address words
							if (pos_q == 6'd20 || pos_q == 6'd35 || pos_q == 6'd37 ||
								pos_q == 6'd51 || pos_q == 6'd53)
								sum_d = sum_q + {12'd0, b};
							if (pos_q == 6'd21 || pos_q == 6'd34 || pos_q == 6'd36 ||
								pos_q == 6'd50 || pos_q == 6'd52)
								sum_d = sum_q + {4'd0, b, 8'd0};
						end
						if (pos_inc == need) begin
							cmd_push = 1'b1;
							cmd.op   = (kind_q == KIND_V4) ? OP_HDR_TO_V6 : OP_HDR_TO_V4;
							set_busy = 1'b1;
							csum_d   = ~f2 & CSUM_MASK;
						end
					end else begin
						cmd_push = 1'b1;
					end
				end
				default: ;
			endcase
			if (last) begin
				if (!cmd_push) begin
					cmd_push = 1'b1;
					cmd      = '{op: OP_DROP, data: 8'd0, last: 1'b1, verdict: VERDICT_DROP};
				end
				pos_d  = '0;
				kind_d = KIND_UNKNOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			kind_q <= KIND_UNKNOWN;
			busy_q <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			kind_q <= kind_d;
			if (set_busy) busy_q <= 1'b1;
			else if (hdr_done) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		et_hi_q <= et_hi_d;
		sum_q   <= sum_d;
		len_q   <= len_d;
		csum_q  <= csum_d;
	end

endmodule

// ----- rtl/core/nht_cmdq.sv -----
// Command queue between the front end and the back end.
`timescale 1ns / 1ps

module nht_cmdq import nht_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	input  logic pop,
	output cmd_t dout,
	output logic full,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (do_pop) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

// ----- rtl/core/nht_back.sv -----
// Back end: expands commands into result bytes and queues them for the consumer.
`timescale 1ns / 1ps

module nht_back import nht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	input  hdr_info_t  info,
	input  logic [7:0] rdata,
	input  logic       pop,
	output logic       cmd_pop,
	output logic       hdr_done,
	output logic [5:0] raddr,
	output result_t    result,
	output logic       empty
);

	localparam int PW = $clog2(OQ_DEPTH);

	logic [5:0]    k_q;
	src_t          src;
	logic [5:0]    last_k;
	logic          is_hdr, at_end, issue;
	logic [15:0]   adj;
	result_t       item;
	logic          valid_s1, ram_s1;
	result_t       item_s1, push_item;
	result_t       oq_q [OQ_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q, used;
	logic          do_pop;

	assign src    = hdr_src(cmd.op, k_q);
	assign last_k = hdr_last(cmd.op);
	assign is_hdr = (cmd.op == OP_HDR_OTHER) || (cmd.op == OP_HDR_TO_V6) ||
	                (cmd.op == OP_HDR_TO_V4);
	assign at_end = !is_hdr || (k_q == last_k);
	assign adj    = (cmd.op == OP_HDR_TO_V6) ? info.len - 16'(HDR_GROWTH)
	                                         : info.len + 16'(HDR_GROWTH);
	// slot reserved for the byte in flight through the RAM read
	assign used     = cnt_q + (PW+1)'(valid_s1);
	assign issue    = cmd_valid && (used < (PW+1)'(OQ_DEPTH));
	assign cmd_pop  = issue && at_end;
	assign hdr_done = issue && is_hdr && (k_q == last_k);
	assign raddr    = src.addr;

	always_comb begin
		item.end_of_frame = cmd.last && at_end;
		item.verdict      = item.end_of_frame ? cmd.verdict : VERDICT_XLAT;
		item.byte_valid   = (cmd.op != OP_DROP);
		item.out_byte     = cmd.data;
		if (is_hdr) begin
			case (src.sel)
				SEL_LEN_HI: item.out_byte = adj[15:8];
				SEL_LEN_LO: item.out_byte = adj[7:0];
				SEL_CS_HI:  item.out_byte = info.csum[15:8];
				SEL_CS_LO:  item.out_byte = info.csum[7:0];
				default:    item.out_byte = src.value;
			endcase
		end
	end

	always_comb begin
		push_item = item_s1;
		if (ram_s1) push_item.out_byte = rdata;
	end

	assign do_pop = pop && !empty;
	assign empty  = (cnt_q == '0);
	assign result = oq_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s1 <= 1'b0;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (issue) k_q <= at_end ? 6'd0 : k_q + 6'd1;
			valid_s1 <= issue;
			if (valid_s1) wp_q <= wp_q + PW'(1);
			if (do_pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(valid_s1) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		ram_s1  <= is_hdr && (src.sel == SEL_RAM);
		if (valid_s1) oq_q[wp_q] <= push_item;
	end

`ifndef SYNTHESIS
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(OQ_DEPTH))
		else $error("result queue overflow");

	a_hdr_holds_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != 6'd0 |-> cmd_valid && is_hdr)
		else $error("header emission lost its command");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 6'(V6_END - 1))
		else $error("header index out of range");

	a_drop_form: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.byte_valid |-> result.end_of_frame &&
		result.verdict == VERDICT_DROP && result.out_byte == 8'd0)
		else $error("malformed drop result");
`endif

endmodule

// ----- rtl/core/nat64_header_translator.sv -----
// Top level of the stateless NAT64 header translator.
//   channel   direction  handshake         payload
//   input     in         push / full       item   (in_item_t)
//   result    out        pop / empty       result (result_t)
// Buffering and payload bytes are taken while full is low; the back end emits
// header bytes one at a time, and while a header of 14, 34 or 54 bytes is emitted
// new bytes are held off by full (header RAM has one read port).
// Results leave through a 4-entry queue; the consumer may stall at will.
// Reset is asynchronous and clears all control state; no clearing pass.
`timescale 1ns / 1ps

module nat64_header_translator import nht_pkg::*; #(
	parameter int CMDQ_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     pop,
	output logic     empty,
	output result_t  result
);

	cmd_t       f_cmd, q_cmd;
	logic       f_push, q_full, q_empty, b_pop, hdr_done, hdr_busy, accept;
	logic       wr_en;
	logic [5:0] wr_addr, raddr;
	logic [7:0] wr_data, rdata;
	hdr_info_t  info;

	assign full   = q_full || hdr_busy;
	assign accept = push && !full;

	nht_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (accept),
		.hdr_done (hdr_done),
		.cmd      (f_cmd),
		.cmd_push (f_push),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.info     (info),
		.hdr_busy (hdr_busy)
	);

	nht_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rdata)
	);

	nht_cmdq #(.DEPTH(CMDQ_DEPTH)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_cmd),
		.pop    (b_pop),
		.dout   (q_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	nht_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (!q_empty),
		.info      (info),
		.rdata     (rdata),
		.pop       (pop),
		.cmd_pop   (b_pop),
		.hdr_done  (hdr_done),
		.raddr     (raddr),
		.result    (result),
		.empty     (empty)
	);

endmodule

// ----- tb/sv/tb_nat64_header_translator.sv -----
// Testbench for the NAT64 header translator: frame stimulus, translation predictor, result checks.
`timescale 1ns / 1ps

module tb_nat64_header_translator;
	import nht_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     push;
	logic     full;
	in_item_t item;
	logic     pop;
	logic     empty;
	result_t  result;

	nat64_header_translator uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.pop(pop), .empty(empty), .result(result)
	);

	// translator state mirror
	logic [7:0] hdr_buf [STORE_DEPTH];
	logic [5:0] pos;
	kind_t      kind;

	result_t expected_bytes [$];
	int      n_errors;
	int      n_results;
	int      n_frames;
	int      n_items;
	longint  cycle_count;
	bit      idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd3000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("nat64_header_translator test failed");
			$finish;
		end
	end

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		n_errors++;
		$display("mismatch at result %0d: %s got %0h expected %0h", n_results, what, got, want);
	endtask

	function automatic void emit(logic [7:0] b, logic v);
		result_t r;
		r.out_byte     = b;
		r.byte_valid   = v;
		r.end_of_frame = 1'b0;
		r.verdict      = VERDICT_XLAT;
		expected_bytes.push_back(r);
	endfunction

	function automatic void emit_eth(logic [7:0] hi, logic [7:0] lo);
		for (int i = 0; i < 6; i++) emit(hdr_buf[6 + i], 1'b1);
		for (int i = 0; i < 6; i++) emit(hdr_buf[i], 1'b1);
		emit(hi, 1'b1);
		emit(lo, 1'b1);
	endfunction

	function automatic void emit_prefix(int at);
		emit(8'h00, 1'b1);
		emit(PFX_B1, 1'b1);
		emit(PFX_B2, 1'b1);
		emit(PFX_B3, 1'b1);
		for (int i = 0; i < 8; i++) emit(8'h00, 1'b1);
		for (int i = 0; i < 4; i++) emit(hdr_buf[at + i], 1'b1);
	endfunction

	function automatic void build_v6_header();
		logic [15:0] plen;
		plen = {hdr_buf[16], hdr_buf[17]} - 16'(HDR_GROWTH);
		emit_eth(8'h86, 8'hdd);
		emit(8'h60, 1'b1);
		for (int i = 0; i < 3; i++) emit(8'h00, 1'b1);
		emit(plen[15:8], 1'b1);
		emit(plen[7:0], 1'b1);
		emit(hdr_buf[23], 1'b1);
		emit(hdr_buf[22], 1'b1);
		emit_prefix(26);
		emit_prefix(30);
	endfunction

	function automatic void build_v4_header();
		logic [7:0]  h [20];
		logic [15:0] tl;
		logic [31:0] sum;
		tl = {hdr_buf[18], hdr_buf[19]} + 16'(HDR_GROWTH);
		h[0] = 8'h45; h[1] = 8'h00; h[2] = tl[15:8]; h[3] = tl[7:0];
		h[4] = 8'h00; h[5] = 8'h00; h[6] = 8'h40; h[7] = 8'h00;
		h[8] = hdr_buf[21]; h[9] = hdr_buf[20]; h[10] = 8'h00; h[11] = 8'h00;
		for (int i = 0; i < 4; i++) begin
			h[12 + i] = hdr_buf[34 + i];
			h[16 + i] = hdr_buf[50 + i];
		end
		sum = '0;
		for (int i = 0; i < 20; i += 2) sum += {16'h0, h[i], h[i + 1]};
		sum = (sum & 32'hffff) + (sum >> 16);
		sum = (sum & 32'hffff) + (sum >> 16);
		sum = ~sum & 32'hffff;
		h[10] = sum[15:8];
		h[11] = sum[7:0];
		emit_eth(8'h08, 8'h00);
		for (int i = 0; i < 20; i++) emit(h[i], 1'b1);
	endfunction

	function automatic void predict_translation(in_item_t it);
		int     n_prior;
		int     need;
		bit     complete;
		n_prior = expected_bytes.size();
		if (kind == KIND_UNKNOWN) begin
			if (pos < 6'(ETH_LEN)) hdr_buf[pos] = it.frame_byte;
			pos = pos + 6'd1;
			if (pos == 6'(ETH_LEN)) begin
				if ({hdr_buf[12], hdr_buf[13]} == ETHERTYPE_V4) kind = KIND_V4;
				else if ({hdr_buf[12], hdr_buf[13]} == ETHERTYPE_V6) kind = KIND_V6;
				else begin
					kind = KIND_OTHER;
					for (int i = 0; i < ETH_LEN; i++) emit(hdr_buf[i], 1'b1);
				end
			end
		end else if (kind == KIND_OTHER) begin
			emit(it.frame_byte, 1'b1);
		end else begin
			need = (kind == KIND_V4) ? V4_END : V6_END;
			if (pos < 6'(need)) begin
				hdr_buf[pos] = it.frame_byte;
				pos = pos + 6'd1;
				if (pos == 6'(need)) begin
					if (kind == KIND_V4) build_v6_header();
					else build_v4_header();
				end
			end else begin
				emit(it.frame_byte, 1'b1);
			end
		end
		if (it.last_byte) begin
			complete = (kind == KIND_OTHER) || (kind == KIND_V4 && pos >= 6'(V4_END)) ||
				(kind == KIND_V6 && pos >= 6'(V6_END));
			if (!complete || expected_bytes.size() == n_prior) begin
				while (expected_bytes.size() > n_prior) void'(expected_bytes.pop_back());
				emit(8'h00, 1'b0);
				expected_bytes[$].end_of_frame = 1'b1;
				expected_bytes[$].verdict = VERDICT_DROP;
			end else begin
				expected_bytes[$].end_of_frame = 1'b1;
				expected_bytes[$].verdict = (kind == KIND_OTHER) ? VERDICT_PASS : VERDICT_XLAT;
			end
			pos = '0;
			kind = KIND_UNKNOWN;
			n_frames++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_bytes.size() == 0) begin
				report("unexpected transaction", result.out_byte, 8'h00);
			end else begin
				result_t w;
				w = expected_bytes.pop_front();
				if (result.out_byte !== w.out_byte) report("out_byte", result.out_byte, w.out_byte);
				if (result.byte_valid !== w.byte_valid)
					report("byte_valid", 8'(result.byte_valid), 8'(w.byte_valid));
				if (result.end_of_frame !== w.end_of_frame)
					report("end_of_frame", 8'(result.end_of_frame), 8'(w.end_of_frame));
				if (result.verdict !== w.verdict)
					report("verdict", 8'(result.verdict), 8'(w.verdict));
			end
			n_results++;
		end
	end

	// receiver: random stall bursts
	initial begin
		int burst;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 10);
				pop <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			pop <= 1'b1;
		end
	end

	// push stays high after return; a drain wait lowers it, and the next call only when it idles first
	task automatic send_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		it.frame_byte = b;
		it.last_byte  = last;
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_translation(it);
		n_items++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] etype, input int len, input bit extreme);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = extreme ? ((i[0]) ? 8'hff : 8'h00) : 8'($urandom_range(0, 255));
			if (i == 12) b = etype[15:8];
			if (i == 13) b = etype[7:0];
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_bytes.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic test_directed();
		send_frame(ETHERTYPE_V4, 34, 1'b1);
		send_frame(16'h0806, 15, 1'b0);
		send_frame(ETHERTYPE_V4, 1, 1'b0);
		send_frame(ETHERTYPE_V4, 13, 1'b0);
		send_frame(ETHERTYPE_V6, 16, 1'b0);
	endtask

	// idle sender so the whole backlog drains
	task automatic test_drain_pause();
		send_frame(ETHERTYPE_V6, 54, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_frames(input int n_bytes);
		int   start;
		int   r;
		int   len;
		logic [15:0] et;
		start = n_items;
		while (n_items - start < n_bytes) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				et = ETHERTYPE_V4; len = $urandom_range(34, 60);
			end else if (r < 8) begin
				et = ETHERTYPE_V6; len = $urandom_range(54, 63);
			end else if (r == 8) begin
				et = 16'($urandom); len = $urandom_range(14, 30);
			end else begin
				et = ($urandom_range(0, 1)) ? ETHERTYPE_V4 : ETHERTYPE_V6;
				len = $urandom_range(1, 53);
			end
			send_frame(et, len, 1'b0);
		end
	endtask

	initial begin
		n_errors = 0; n_results = 0; n_frames = 0; n_items = 0; cycle_count = 0;
		clk = 1'b0;
		idle_on = 1'b1;
		pos = '0;
		kind = KIND_UNKNOWN;
		push = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_drain_pause();
		test_random_frames(1);
		idle_on = 1'b0;
		test_random_frames(1);
		wait_drained();
		$display("covered %0d frames, %0d bytes in, %0d transactions out",
			n_frames, n_items, n_results);
		$display("mix of IPv4, IPv6, other ethertypes and truncated frames with stalls");
		if (n_errors == 0) begin
			$display("nat64_header_translator test passed");
		end else begin
			$display("nat64_header_translator test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/nht_pkg.sv
rtl/core/nht_ram.sv
rtl/core/nht_front.sv
rtl/core/nht_cmdq.sv
rtl/core/nht_back.sv
rtl/core/nat64_header_translator.sv
tb/sv/tb_nat64_header_translator.sv
